>>> hw/rtl/tmrb_pkg.sv
// ----------------------------------------------------------------------------
// tmrb_pkg
// Types and constants shared by the trace message ring buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmrb_pkg;

  localparam int RING_BYTES   = 1024;
  localparam int HEADER_BYTES = 10;

  localparam int PTR_W  = $clog2(RING_BYTES);
  localparam int CNT_W  = PTR_W + 1;
  localparam int LEN_W  = 9;
  localparam int HCNT_W = $clog2(HEADER_BYTES);
  localparam int SUM_W  = (CNT_W > LEN_W) ? CNT_W + 1 : LEN_W + 1;
  localparam int SEQ_W  = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_READ    = 2'd2,
    ACT_SKIP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FILTERED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ALL = 2'd1,
    MODE_ONE = 2'd2
  } trace_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACE_MODE = 1'd0,
    CFG_TRACE_PORT = 1'd1
  } cfg_idx_e;

  typedef enum logic {
    RSEL_LEN  = 1'b0,
    RSEL_BYTE = 1'b1
  } rsel_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  port;
    logic        direction;
    logic [7:0]  msg_kind;
    logic [7:0]  data_size;
    logic [7:0]  data_byte;
    logic [31:0] timestamp_us;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        last_of_record;
    status_e     status;
    logic [10:0] free_bytes;
    logic [31:0] drop_total;
    logic        is_empty;
  } out_t;

  typedef struct packed {
    logic    latch_in;
    logic    st_load;
    status_e st_code;
    logic    reserve;
    logic    drop;
    logic    pay_write;
    logic    hdr_write;
    logic    len_load;
    logic    byte_take;
    logic    skip_free;
    rsel_e   rsel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    rec_open;
    logic    pass;
    logic    fits;
    logic    no_record;
    logic    hdr_last;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/trace_message_ring_buffer.sv
// ----------------------------------------------------------------------------
// trace_message_ring_buffer
// Byte ring of variable-length trace records with filtering, drop counting
// and byte-wise readout of the oldest complete record.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i) takes one beat per item:
//   start record, payload byte, read byte or skip record. Output channel
//   (out_valid_o / out_stall_i / out_o) returns exactly one beat per item.
//   Items are handled one at a time by the sequencer; the input is stalled
//   from acceptance until the result is loaded into the output register.
//   An accepted start writes one header byte per cycle into the ring memory
//   (one write and one read port); skip and read fetch the record length
//   from the ring, and a read then fetches the data byte. A waiting result
//   does not block acceptance of the next item; the block only holds in its
//   final state while the output register is still full and stalled.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) are registered
//   and are meant for idle periods. Reset clears pointers, counters and
//   configuration; the ring memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module trace_message_ring_buffer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tmrb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire tmrb_pkg::in_t                  in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output tmrb_pkg::out_t                      out_o
);

  tmrb_pkg::cmd_t cmd;
  tmrb_pkg::sts_t sts;

  tmrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmrb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_last_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last_of_record |-> out_o.status == tmrb_pkg::ST_OK)
    else $error("end of record flagged on a failed item");

  a_byte_zero_on_fail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != tmrb_pkg::ST_OK) |-> out_o.read_byte == 8'd0)
    else $error("nonzero read byte on a failed item");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tmrb_ctrl.sv
// ----------------------------------------------------------------------------
// tmrb_ctrl
// Sequencer: decodes each item and steps the datapath through header writes,
// record length fetch, byte read and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire tmrb_pkg::sts_t sts_i,
  output tmrb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_HDR,
    S_LEN,
    S_BYTE,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_ready;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.st_code = tmrb_pkg::ST_OK;
    cmd_o.rsel    = tmrb_pkg::RSEL_LEN;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.st_load = 1'b1;
        state_d       = S_RESP;
        case (sts_i.action)
          tmrb_pkg::ACT_START: begin
            if (sts_i.rec_open) begin
              cmd_o.st_code = tmrb_pkg::ST_IGNORED;
            end else if (!sts_i.pass) begin
              cmd_o.st_code = tmrb_pkg::ST_FILTERED;
            end else if (!sts_i.fits) begin
              cmd_o.st_code = tmrb_pkg::ST_DROPPED;
              cmd_o.drop    = 1'b1;
            end else begin
              cmd_o.reserve = 1'b1;
              state_d       = S_HDR;
            end
          end
          tmrb_pkg::ACT_PAYLOAD: begin
            if (!sts_i.rec_open) begin
              cmd_o.st_code = tmrb_pkg::ST_IGNORED;
            end else begin
              cmd_o.pay_write = 1'b1;
            end
          end
          default: begin
            if (sts_i.no_record) begin
              cmd_o.st_code = tmrb_pkg::ST_EMPTY;
            end else begin
              cmd_o.rsel = tmrb_pkg::RSEL_LEN;
              state_d    = S_LEN;
            end
          end
        endcase
      end
      S_HDR: begin
        cmd_o.hdr_write = 1'b1;
        if (sts_i.hdr_last) begin
          state_d = S_RESP;
        end
      end
      S_LEN: begin
        if (sts_i.action == tmrb_pkg::ACT_SKIP) begin
          cmd_o.skip_free = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.len_load = 1'b1;
          cmd_o.rsel     = tmrb_pkg::RSEL_BYTE;
          state_d        = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd_o.byte_take = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tmrb_dp.sv
// ----------------------------------------------------------------------------
// tmrb_dp
// Datapath: byte ring memory, pointers, space and record accounting,
// sequence and drop counters, configuration and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrb_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tmrb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [7:0]                        cfg_wdata_i,
  input  wire tmrb_pkg::in_t                     in_i,
  input  wire tmrb_pkg::cmd_t                    cmd_i,
  output tmrb_pkg::sts_t                         sts_o,
  output tmrb_pkg::out_t                         out_o
);

  localparam int PW = tmrb_pkg::PTR_W;
  localparam int CW = tmrb_pkg::CNT_W;
  localparam int LW = tmrb_pkg::LEN_W;
  localparam int SW = tmrb_pkg::SUM_W;
  localparam int HW = tmrb_pkg::HCNT_W;
  localparam int QW = tmrb_pkg::SEQ_W;

  logic [7:0] mem [tmrb_pkg::RING_BYTES];

  tmrb_pkg::in_t in_q;
  logic [1:0]    mode_q;
  logic [7:0]    sel_q;
  logic [PW-1:0] rp_q, wp_q;
  logic [CW-1:0] free_q, cnt_q;
  logic [31:0]   drop_q;
  logic [QW-1:0] seq_q;
  logic [7:0]    rem_q;
  logic [LW-1:0] prog_q, len_q;
  logic [HW-1:0] hcnt_q;
  logic [7:0]    rdata_q;
  logic [7:0]    res_byte_q;
  logic          res_last_q;
  tmrb_pkg::status_e res_status_q;
  tmrb_pkg::out_t out_q;

  logic [PW-1:0] raddr;
  logic          mem_we;
  logic [7:0]    wdata, hdr_byte;
  logic [LW-1:0] need, rec_len, free_len, prog_inc;
  logic [SW-1:0] free_sum;
  logic [CW-1:0] free_back;
  logic          byte_last, do_free;

  // header: time LE, sequence LE, port, direction, type, size
  always_comb begin
    case (hcnt_q)
      HW'(0):  hdr_byte = in_q.timestamp_us[7:0];
      HW'(1):  hdr_byte = in_q.timestamp_us[15:8];
      HW'(2):  hdr_byte = in_q.timestamp_us[23:16];
      HW'(3):  hdr_byte = in_q.timestamp_us[31:24];
      HW'(4):  hdr_byte = seq_q[7:0];
      HW'(5):  hdr_byte = seq_q[15:8];
      HW'(6):  hdr_byte = in_q.port;
      HW'(7):  hdr_byte = {7'd0, in_q.direction};
      HW'(8):  hdr_byte = in_q.msg_kind;
      default: hdr_byte = in_q.data_size;
    endcase
  end

  assign need     = LW'(tmrb_pkg::HEADER_BYTES) + LW'(in_q.data_size);
  assign rec_len  = LW'(tmrb_pkg::HEADER_BYTES) + LW'(rdata_q);
  assign prog_inc = prog_q + LW'(1);
  assign byte_last = (prog_inc >= len_q);
  assign free_len = cmd_i.skip_free ? rec_len : len_q;
  assign free_sum = SW'(free_q) + SW'(free_len);
  assign free_back = (free_sum > SW'(tmrb_pkg::RING_BYTES)) ?
                     CW'(tmrb_pkg::RING_BYTES) : CW'(free_sum);
  assign do_free  = cmd_i.skip_free || (cmd_i.byte_take && byte_last);

  assign raddr  = (cmd_i.rsel == tmrb_pkg::RSEL_LEN) ?
                  rp_q + PW'(tmrb_pkg::HEADER_BYTES - 1) : rp_q + PW'(prog_q);
  assign mem_we = cmd_i.pay_write || cmd_i.hdr_write;
  assign wdata  = cmd_i.pay_write ? in_q.data_byte : hdr_byte;

  always_comb begin
    sts_o.action    = in_q.action;
    sts_o.rec_open  = (rem_q != 8'd0);
    sts_o.pass      = (mode_q == tmrb_pkg::MODE_ALL) ||
                      ((mode_q == tmrb_pkg::MODE_ONE) && (in_q.port == sel_q));
    sts_o.fits      = (SW'(need) <= SW'(free_q));
    sts_o.no_record = (cnt_q == '0);
    sts_o.hdr_last  = (hcnt_q == HW'(tmrb_pkg::HEADER_BYTES - 1));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // input, record length, result and output registers (no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_i;
    end
    if (cmd_i.len_load) begin
      len_q <= rec_len;
    end
    if (cmd_i.st_load) begin
      res_status_q <= cmd_i.st_code;
      res_byte_q   <= 8'd0;
      res_last_q   <= 1'b0;
    end else if (cmd_i.byte_take) begin
      res_byte_q <= rdata_q;
      res_last_q <= byte_last;
    end
    if (cmd_i.out_load) begin
      out_q.read_byte      <= res_byte_q;
      out_q.last_of_record <= res_last_q;
      out_q.status         <= res_status_q;
      out_q.free_bytes     <= 11'(free_q);
      out_q.drop_total     <= drop_q;
      out_q.is_empty       <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      sel_q  <= 8'd0;
      rp_q   <= '0;
      wp_q   <= '0;
      free_q <= CW'(tmrb_pkg::RING_BYTES);
      cnt_q  <= '0;
      drop_q <= 32'd0;
      seq_q  <= '0;
      rem_q  <= 8'd0;
      prog_q <= '0;
      hcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tmrb_pkg::CFG_TRACE_MODE: mode_q <= cfg_wdata_i[1:0];
          tmrb_pkg::CFG_TRACE_PORT: sel_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.drop) begin
        drop_q <= drop_q + 32'd1;
      end
      if (cmd_i.reserve) begin
        free_q <= free_q - CW'(need);
        hcnt_q <= '0;
      end
      if (mem_we) begin
        wp_q <= wp_q + PW'(1);
      end
      if (cmd_i.hdr_write) begin
        hcnt_q <= hcnt_q + HW'(1);
        if (sts_o.hdr_last) begin
          seq_q <= seq_q + QW'(1);
          rem_q <= in_q.data_size;
          if (in_q.data_size == 8'd0) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
      end
      if (cmd_i.pay_write) begin
        rem_q <= rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (do_free) begin
        rp_q   <= rp_q + PW'(free_len);
        free_q <= free_back;
        cnt_q  <= cnt_q - CW'(1);
        prog_q <= '0;
      end else if (cmd_i.byte_take) begin
        prog_q <= prog_inc;
      end
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire
